@@ hw/rtl/pida_pkg.sv @@
// ----------------------------------------------------------------------------
// pida_pkg
// shared types, widths and codes for the positional insert/delete array
// ----------------------------------------------------------------------------
package pida_pkg;

  // list capacity, number of cells in the chain
  localparam int DEPTH     = 32;

  // fixed field widths
  localparam int DATA_W    = 32;
  localparam int POS_W     = 6;
  localparam int FUNC_W    = 2;
  localparam int STAT_W    = 2;
  localparam int OUT_IDX_W = 6;
  localparam int OUT_CNT_W = 6;

  // widths that follow the capacity
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CMP_W     = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [1:0]        cell_op_t;

  // operation codes
  localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] OP_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] OP_READ   = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

  // per-cycle cell actions
  localparam cell_op_t CELL_HOLD   = 2'd0;
  localparam cell_op_t CELL_INSERT = 2'd1;
  localparam cell_op_t CELL_DELETE = 2'd2;
  localparam cell_op_t CELL_ROTATE = 2'd3;

  // broadcast to every cell: what to do and at which cell it starts or ends
  typedef struct packed {
    cell_op_t op;
    idx_t     sel;
  } cell_ctl_t;

endpackage

@@ hw/rtl/pida_cell.sv @@
// ----------------------------------------------------------------------------
// pida_cell
// one list slot: holds one word and takes it from a neighbor on a shift
// ----------------------------------------------------------------------------
module pida_cell (
  input  logic              clk,
  input  pida_pkg::cell_ctl_t ctl,
  input  pida_pkg::idx_t    my_idx,
  input  pida_pkg::data_t   left,
  input  pida_pkg::data_t   right,
  input  pida_pkg::data_t   head,
  input  pida_pkg::data_t   data_in,
  output pida_pkg::data_t   value
);
  import pida_pkg::*;

  data_t value_next;

  always_comb begin
    value_next = value;
    unique case (ctl.op)
      CELL_HOLD: begin
        value_next = value;
      end
      CELL_INSERT: begin
        // slots above the insert point move up, the insert point takes the new word
        if (my_idx == ctl.sel) begin
          value_next = data_in;
        end else if (my_idx > ctl.sel) begin
          value_next = left;
        end
      end
      CELL_DELETE: begin
        // slots from the delete point on move down
        if (my_idx >= ctl.sel) begin
          value_next = right;
        end
      end
      CELL_ROTATE: begin
        // rotate the used part of the list by one, head wraps to the end
        if (my_idx == ctl.sel) begin
          value_next = head;
        end else if (my_idx < ctl.sel) begin
          value_next = right;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

@@ hw/rtl/positional_insert_delete_array.sv @@
// ----------------------------------------------------------------------------
// positional_insert_delete_array
// ordered list of signed words with insert and delete by position and read-out
// ----------------------------------------------------------------------------
// insert, delete, bad requests and empty read-out give their word from the output
//   register in the cycle after acceptance
// insert and delete are taken back to back while the output is free; a read-out
//   holds off the input until its last word is sent, one rotation of the cell chain per word
// reset: synchronous, clears the entry count and the handshake state; cell
//   contents are not cleared and are only read below the count
module positional_insert_delete_array (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [5:0] position, [37:6] data_in, [39:38] zero
  input  logic [1:0]  s_tuser,   // [1:0] func
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [31:0] data_out, [37:32] entry_index,
                                 // [43:38] entry_count, [47:44] zero
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic        m_tlast
);
  import pida_pkg::*;

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  cnt_t  count;              // entries in use
  logic  busy;               // read-out in progress
  idx_t  rd_idx;             // index of the next word to send during read-out

  // output register
  logic [STAT_W-1:0]    out_status;
  data_t                out_data;
  logic [OUT_IDX_W-1:0] out_index;
  logic [OUT_CNT_W-1:0] out_count;
  logic                 out_last;

  // --------------------------------------------------------------------------
  // input word unpacking
  // --------------------------------------------------------------------------
  logic [FUNC_W-1:0] func;
  logic [POS_W-1:0]  position;
  data_t             data_in;

  assign func     = s_tuser;
  assign position = s_tdata[POS_W-1:0];
  assign data_in  = s_tdata[POS_W +: DATA_W];

  // --------------------------------------------------------------------------
  // handshake
  // --------------------------------------------------------------------------
  logic out_free;
  logic acc;
  logic rd_step;

  // output register can take a new word this cycle
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !busy && out_free;
  assign acc      = s_tvalid && s_tready;
  // during read-out one entry leaves per free output slot
  assign rd_step  = busy && out_free;

  // --------------------------------------------------------------------------
  // request checks
  // --------------------------------------------------------------------------
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             is_full;
  logic             ins_bad;
  logic             del_bad;
  logic             ins_ok;
  logic             del_ok;
  idx_t             pos_m1;
  idx_t             cnt_m1;
  logic             rd_last;
  logic             rd_start;

  assign pos_ext = CMP_W'(position);
  assign cnt_ext = CMP_W'(count);
  assign is_full = (count == CNT_W'(DEPTH));
  // position is 1-based: insert allows up to count + 1, delete up to count
  assign ins_bad = (position == '0) || (pos_ext > cnt_ext + CMP_W'(1));
  assign del_bad = (position == '0) || (pos_ext > cnt_ext);
  // full is checked before the position
  assign ins_ok  = acc && (func == OP_INSERT) && !is_full && !ins_bad;
  assign del_ok  = acc && (func == OP_DELETE) && !del_bad;
  // only used when the request is valid, then it fits the cell index
  assign pos_m1  = IDX_W'(pos_ext - CMP_W'(1));
  assign cnt_m1  = IDX_W'(count - CNT_W'(1));
  assign rd_last = (rd_idx == cnt_m1);
  // a read-out of a non-empty list keeps the block busy until every entry is sent
  assign rd_start = acc && (func == OP_READ) && (count != '0);

  logic [STAT_W-1:0] req_status;

  always_comb begin
    req_status = ST_OK;
    unique case (func)
      OP_INSERT: begin
        if (is_full) begin
          req_status = ST_FULL;
        end else if (ins_bad) begin
          req_status = ST_BADPOS;
        end
      end
      OP_DELETE: begin
        if (del_bad) begin
          req_status = ST_BADPOS;
        end
      end
      default: begin
        req_status = ST_OK;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // cell chain
  // --------------------------------------------------------------------------
  cell_ctl_t ctl;
  data_t     cell_val [DEPTH];

  always_comb begin
    ctl.op  = CELL_HOLD;
    ctl.sel = '0;
    if (rd_step) begin
      // rotate the used slots so the next entry sits in cell 0
      ctl.op  = CELL_ROTATE;
      ctl.sel = cnt_m1;
    end else if (ins_ok) begin
      ctl.op  = CELL_INSERT;
      ctl.sel = pos_m1;
    end else if (del_ok) begin
      ctl.op  = CELL_DELETE;
      ctl.sel = pos_m1;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    data_t left_val;
    data_t right_val;

    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_inner_l
      assign left_val = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_inner_r
      assign right_val = cell_val[i+1];
    end

    pida_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .my_idx  (IDX_W'(i)),
      .left    (left_val),
      .right   (right_val),
      .head    (cell_val[0]),
      .data_in (data_in),
      .value   (cell_val[i])
    );
  end

  // --------------------------------------------------------------------------
  // count and read-out control
  // --------------------------------------------------------------------------
  cnt_t count_next;

  always_comb begin
    count_next = count;
    if (ins_ok) begin
      count_next = count + CNT_W'(1);
    end else if (del_ok) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      busy   <= 1'b0;
      rd_idx <= '0;
    end else begin
      count <= count_next;
      if (rd_start) begin
        busy   <= 1'b1;
        rd_idx <= '0;
      end else if (rd_step) begin
        rd_idx <= rd_idx + IDX_W'(1);
        if (rd_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic out_load;

  // every accepted word but the start of a non-empty read-out answers at once
  assign out_load = (acc && !rd_start) || rd_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_step) begin
      out_status <= ST_OK;
      out_data   <= cell_val[0];
      out_index  <= OUT_IDX_W'(rd_idx);
      out_count  <= OUT_CNT_W'(count);
      out_last   <= rd_last;
    end else if (acc && !rd_start) begin
      out_status <= req_status;
      out_data   <= '0;
      out_index  <= '0;
      out_count  <= OUT_CNT_W'(count_next);
      out_last   <= 1'b1;
    end
  end

  assign m_tdata = {4'b0, out_count, out_index, out_data};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_busy_nonempty: assert property (@(posedge clk) disable iff (rst)
    busy |-> (count != '0))
    else $error("read-out running on an empty list");

  a_rd_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (CNT_W'(rd_idx) < count))
    else $error("read-out index past the entry count");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_tready)
    else $error("input taken during read-out");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    ins_ok |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert did not grow the list");

  a_readout_end: assert property (@(posedge clk) disable iff (rst)
    (rd_step && rd_last) |=> (!busy && m_tvalid && m_tlast))
    else $error("read-out did not end on its last word");

endmodule

@@ tb/sv/tb_positional_insert_delete_array.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_insert_delete_array
// self-checking bench for the positional insert/delete list
// ----------------------------------------------------------------------------
// a shadow copy of the list predicts every result word from the accepted
// request words; a short directed sequence hits the empty, bad-position and
// operand-extreme cases, then random phases fill the list to full, mix
// operations and drain it again, with random idle bursts on both streams
module tb_positional_insert_delete_array;
  import pida_pkg::*;

  // code not used by the block, must come back as a plain status word
  localparam logic [FUNC_W-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 440;
  localparam int PHASE_LEN    = 45;
  localparam int QUIET_FROM   = 400;
  localparam int DRAIN_CYCLES = 40;

  typedef enum int {PH_FILL, PH_MIX, PH_DRAIN} phase_t;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [DATA_W-1:0]    value;
    logic [OUT_IDX_W-1:0] index;
    logic [OUT_CNT_W-1:0] count;
    logic                 last;
  } list_word_t;

  // shadow of the list contents and the words it must produce
  class list_shadow;
    data_t      cells [DEPTH];
    int         count;
    list_word_t expected_words [$];
    int         errors;
    int         words_checked;
    int         readouts;
    int         full_hits;
    int         badpos_hits;

    function new();
      count = 0;
      errors = 0;
      words_checked = 0;
      readouts = 0;
      full_hits = 0;
      badpos_hits = 0;
    endfunction

    function void push(logic [STAT_W-1:0] st, data_t v, int idx, int cnt, bit lst);
      list_word_t w;
      w.status = st;
      w.value  = v;
      w.index  = idx[OUT_IDX_W-1:0];
      w.count  = cnt[OUT_CNT_W-1:0];
      w.last   = lst;
      expected_words.push_back(w);
    endfunction

    function void note_request(logic [FUNC_W-1:0] f, logic [POS_W-1:0] pos, data_t v);
      int p;
      logic [STAT_W-1:0] st;
      p = int'(pos);
      st = ST_OK;
      if (f == OP_READ) begin
        readouts++;
        if (count == 0) begin
          push(ST_OK, '0, 0, 0, 1'b1);
        end else begin
          for (int i = 0; i < count; i++)
            push(ST_OK, cells[i], i, count, i + 1 == count);
        end
        return;
      end
      if (f == OP_INSERT) begin
        if (count >= DEPTH) begin
          st = ST_FULL;
          full_hits++;
        end else if (p < 1 || p > count + 1) begin
          st = ST_BADPOS;
          badpos_hits++;
        end else begin
          for (int i = count; i >= p; i--)
            cells[i] = cells[i-1];
          cells[p-1] = v;
          count++;
        end
      end else if (f == OP_DELETE) begin
        if (p < 1 || p > count) begin
          st = ST_BADPOS;
          badpos_hits++;
        end else begin
          for (int i = p - 1; i + 1 < count; i++)
            cells[i] = cells[i+1];
          count--;
        end
      end
      push(st, '0, 0, count, 1'b1);
    endfunction

    function void report(string field, logic [DATA_W-1:0] e, logic [DATA_W-1:0] a);
      $display("%0t ns: mismatch on %s, expected %h actual %h", $time, field, e, a);
      errors++;
    endfunction

    function void check_word(list_word_t got);
      list_word_t e;
      if (expected_words.size() == 0) begin
        $display("%0t ns: unexpected result word, actual %h", $time, got);
        errors++;
        return;
      end
      e = expected_words.pop_front();
      words_checked++;
      if (got.status !== e.status)
        report("status", DATA_W'(e.status), DATA_W'(got.status));
      if (got.value  !== e.value)
        report("data_out", e.value, got.value);
      if (got.index  !== e.index)
        report("entry_index", DATA_W'(e.index), DATA_W'(got.index));
      if (got.count  !== e.count)
        report("entry_count", DATA_W'(e.count), DATA_W'(got.count));
      if (got.last   !== e.last)
        report("last", DATA_W'(e.last), DATA_W'(got.last));
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // [5:0] position, [37:6] data_in, [39:38] zero
  logic [1:0]  s_tuser = '0;   // [1:0] func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // [31:0] data_out, [37:32] entry_index,
                               // [43:38] entry_count, [47:44] zero
  logic [1:0]  m_tuser;        // [1:0] status
  logic        m_tlast;

  list_shadow shadow = new();
  bit         quiet = 1'b0;    // no idling on either side once set

  positional_insert_delete_array dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5ms;
    $display("timeout with %0d words still expected", shadow.expected_words.size());
    $display("FAIL");
    $finish;
  end

  // one request word; valid stays high straight into the next word unless
  // an idle burst is taken first
  task automatic send_request(logic [FUNC_W-1:0] f, logic [POS_W-1:0] pos, data_t v);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= {2'b00, v, pos};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    shadow.note_request(f, pos, v);
  endtask

  // result side: ready in random stretches with stall bursts in between
  initial begin
    wait (rst == 1'b0);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      shadow.check_word({m_tuser, m_tdata[31:0], m_tdata[37:32], m_tdata[43:38], m_tlast});
  end

  initial begin
    logic [FUNC_W-1:0] f;
    logic [POS_W-1:0]  pos;
    data_t             v;
    phase_t            phase;
    int                roll;
    int                wait_cycles;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty list, bad positions, extremes, every operation
    send_request(OP_READ,   6'd0,  32'h0000_0000);
    send_request(OP_DELETE, 6'd1,  32'h0000_0000);
    send_request(OP_INSERT, 6'd0,  32'h1234_5678);
    send_request(OP_INSERT, 6'd2,  32'h1234_5678);
    send_request(OP_INSERT, 6'd1,  32'h7fff_ffff);
    send_request(OP_INSERT, 6'd2,  32'h8000_0000);
    send_request(OP_INSERT, 6'd1,  32'h0000_0000);
    send_request(OP_INSERT, 6'd2,  32'hffff_ffff);
    send_request(OP_INSERT, 6'd63, 32'hffff_ffff);
    send_request(OP_READ,   6'd63, 32'hffff_ffff);
    send_request(OP_UNUSED, 6'd63, 32'hffff_ffff);
    send_request(OP_DELETE, 6'd0,  32'h0000_0000);
    send_request(OP_DELETE, 6'd5,  32'h0000_0000);
    send_request(OP_DELETE, 6'd63, 32'h0000_0000);
    send_request(OP_DELETE, 6'd4,  32'h0000_0000);
    send_request(OP_DELETE, 6'd1,  32'h0000_0000);
    send_request(OP_READ,   6'd0,  32'h0000_0000);
    send_request(OP_DELETE, 6'd1,  32'h0000_0000);
    send_request(OP_DELETE, 6'd1,  32'h0000_0000);
    send_request(OP_READ,   6'd0,  32'h0000_0000);

    // random: fill to full, mixed traffic, drain, repeated
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == QUIET_FROM)
        quiet = 1'b1;
      phase = phase_t'((k / PHASE_LEN) % 3);
      roll = $urandom_range(0, 99);
      v = $urandom;
      case ($urandom_range(0, 15))
        0: v = 32'h8000_0000;
        1: v = 32'h7fff_ffff;
        2: v = 32'hffff_ffff;
        3: v = 32'h0000_0000;
        default: ;
      endcase
      // default to a well-formed insert, then adjust by phase
      f = OP_INSERT;
      pos = POS_W'($urandom_range(1, shadow.count + 1));
      case (phase)
        PH_FILL: begin
          if (roll < 60) begin
            pos = POS_W'(shadow.count + 1);
          end else if (roll < 80) begin
          end else if (roll < 88) begin
            f = OP_READ;
          end else if (roll < 92) begin
            f = OP_DELETE;
          end else begin
            roll = 100;
          end
        end
        PH_MIX: begin
          if (roll < 35) begin
          end else if (roll < 70) begin
            f = OP_DELETE;
          end else if (roll < 85) begin
            f = OP_READ;
          end else begin
            roll = 100;
          end
        end
        default: begin
          if (roll < 65) begin
            f = OP_DELETE;
          end else if (roll < 75) begin
          end else if (roll < 85) begin
            f = OP_READ;
          end else begin
            roll = 100;
          end
        end
      endcase
      if (f == OP_DELETE)
        pos = (shadow.count > 0) ? POS_W'($urandom_range(1, shadow.count)) : 6'd1;
      if (roll == 100) begin
        // noise: any code, any position
        f = FUNC_W'($urandom_range(0, 3));
        pos = POS_W'($urandom_range(0, 63));
      end
      send_request(f, pos, v);
    end
    s_tvalid <= 1'b0;

    wait_cycles = 0;
    while (shadow.expected_words.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d result words over %0d read-outs", shadow.words_checked,
             shadow.readouts);
    $display("full-list inserts %0d, bad positions %0d", shadow.full_hits,
             shadow.badpos_hits);
    if (shadow.errors == 0 && shadow.expected_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d errors, %0d words never arrived", shadow.errors,
               shadow.expected_words.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/pida_pkg.sv
hw/rtl/pida_cell.sv
hw/rtl/positional_insert_delete_array.sv
tb/sv/tb_positional_insert_delete_array.sv
